FILE: rtl/core/ultrasonic_echo_ranger_unit_macros.svh
// assertion macros for the ultrasonic echo ranger unit
// used by the top level only, expects clk and rst_n in scope
`ifndef ULTRASONIC_ECHO_RANGER_UNIT_MACROS_SVH
`define ULTRASONIC_ECHO_RANGER_UNIT_MACROS_SVH

// same-cycle implication, checked out of reset
`define EUR_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("eur assertion failed");

// next-cycle implication, checked out of reset
`define EUR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("eur assertion failed");

`endif

FILE: rtl/core/eur_pkg.sv
// shared types, constants and helpers for the ultrasonic echo ranger
// no dependencies
package eur_pkg;

  localparam int COUNT_W    = 17;
  localparam int DIST_W     = 10;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;

  typedef logic [COUNT_W-1:0]    count_t;
  typedef logic [DIST_W-1:0]     dist_t;
  typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;

  localparam count_t CNT_MAX = {COUNT_W{1'b1}};

  // register indexes
  localparam cfg_idx_t REG_TRIG_WIDTH  = 3'd0;
  localparam cfg_idx_t REG_RISE_TMO    = 3'd1;
  localparam cfg_idx_t REG_ECHO_MAX    = 3'd2;
  localparam cfg_idx_t REG_HOLDOFF     = 3'd3;

  // reset values
  localparam logic [7:0]  RST_TRIG_WIDTH = 8'd10;
  localparam logic [15:0] RST_RISE_TMO   = 16'd5000;
  localparam logic [15:0] RST_ECHO_MAX   = 16'd25000;
  localparam logic [16:0] RST_HOLDOFF    = 17'd100000;

  localparam dist_t TIMEOUT_CODE = 10'd999;

  // ticks / 58 by reciprocal: exact for ticks below 174762, so for any 16-bit value
  localparam int          CM_DIV     = 58;
  localparam int          DIV_SHIFT  = 22;
  localparam logic [16:0] DIV_RECIP  = 17'((2 ** DIV_SHIFT + CM_DIV - 1) / CM_DIV);
  localparam count_t      DIV_LIMIT  = COUNT_W'(CM_DIV * (int'(TIMEOUT_CODE) + 1));

  typedef struct packed {
    logic [7:0]  trig_width;
    logic [15:0] rise_tmo;
    logic [15:0] echo_max;
    logic [16:0] holdoff;
  } cfg_t;

  typedef struct packed {
    logic  trig;
    logic  busy;
    logic  valid;
    dist_t dist_cm;
    logic  tmo;
  } res_t;

  // distance in cm, saturated at the timeout code
  function automatic dist_t cm_from_ticks(input count_t ticks);
    logic [32:0] prod;
    dist_t       q;
    prod = ticks[15:0] * DIV_RECIP;
    q    = prod[DIV_SHIFT+DIST_W-1:DIV_SHIFT];
    if (ticks >= DIV_LIMIT) begin
      q = TIMEOUT_CODE;
    end
    return q;
  endfunction

endpackage

FILE: rtl/core/eur_cfg.sv
// configuration register bank of the echo ranger
// depends on eur_pkg
module eur_cfg
  import eur_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      wr_en,
  input  cfg_idx_t  wr_idx,
  input  cfg_data_t wr_data,
  output cfg_t      cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (wr_idx)
        REG_TRIG_WIDTH: cfg_nxt.trig_width = wr_data[7:0];
        REG_RISE_TMO:   cfg_nxt.rise_tmo   = wr_data[15:0];
        REG_ECHO_MAX:   cfg_nxt.echo_max   = wr_data[15:0];
        REG_HOLDOFF:    cfg_nxt.holdoff    = wr_data[16:0];
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.trig_width <= RST_TRIG_WIDTH;
      cfg_r.rise_tmo   <= RST_RISE_TMO;
      cfg_r.echo_max   <= RST_ECHO_MAX;
      cfg_r.holdoff    <= RST_HOLDOFF;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: rtl/core/eur_core.sv
// measurement sequencer: phase and tick counter, one tick per advance
// depends on eur_pkg
module eur_core
  import eur_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic adv,
  input  logic start,
  input  logic echo,
  input  cfg_t cfg,
  output res_t res
);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_TRIG,
    PH_WAIT,
    PH_ECHO,
    PH_HOLD
  } phase_t;

  phase_t phase_r, phase_nxt, ph_cur;
  count_t cnt_r, cnt_nxt, cnt_cur, bumped;
  count_t width;
  res_t   res_c;

  always_comb begin
    width = (cfg.trig_width == 8'd0) ? COUNT_W'(1) : COUNT_W'(cfg.trig_width);

    // start is taken only from idle and restarts the count
    ph_cur  = phase_r;
    cnt_cur = cnt_r;
    if (phase_r == PH_IDLE && start) begin
      ph_cur  = PH_TRIG;
      cnt_cur = '0;
    end
    bumped = (cnt_cur == CNT_MAX) ? CNT_MAX : cnt_cur + COUNT_W'(1);

    phase_nxt   = ph_cur;
    cnt_nxt     = cnt_cur;
    res_c       = '0;

    case (ph_cur)
      PH_IDLE: begin
        phase_nxt = PH_IDLE;
      end
      PH_TRIG: begin
        res_c.trig = 1'b1;
        if (bumped >= width || bumped == CNT_MAX) begin
          phase_nxt = PH_WAIT;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = bumped;
        end
      end
      PH_WAIT: begin
        if (echo) begin
          phase_nxt = PH_ECHO;
          cnt_nxt   = '0;
        end else if (bumped > COUNT_W'(cfg.rise_tmo) || bumped == CNT_MAX) begin
          res_c.valid   = 1'b1;
          res_c.tmo     = 1'b1;
          res_c.dist_cm = TIMEOUT_CODE;
          phase_nxt     = PH_IDLE;
          cnt_nxt       = '0;
        end else begin
          cnt_nxt = bumped;
        end
      end
      PH_ECHO: begin
        if (!echo) begin
          res_c.valid   = 1'b1;
          res_c.dist_cm = cm_from_ticks(bumped);
          cnt_nxt       = '0;
          phase_nxt     = (cfg.holdoff == 17'd0) ? PH_IDLE : PH_HOLD;
        end else if (bumped > COUNT_W'(cfg.echo_max) || bumped == CNT_MAX) begin
          res_c.valid   = 1'b1;
          res_c.tmo     = 1'b1;
          res_c.dist_cm = TIMEOUT_CODE;
          phase_nxt     = PH_IDLE;
          cnt_nxt       = '0;
        end else begin
          cnt_nxt = bumped;
        end
      end
      PH_HOLD: begin
        if (bumped >= COUNT_W'(cfg.holdoff) || bumped == CNT_MAX) begin
          phase_nxt = PH_IDLE;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = bumped;
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
        cnt_nxt   = '0;
      end
    endcase

    res_c.busy = (phase_nxt != PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      cnt_r   <= '0;
    end else if (adv) begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  assign res = res_c;

endmodule

FILE: rtl/core/ultrasonic_echo_ranger_unit.sv
// top level of the ultrasonic echo ranger: handshake stages around the sequencer
// depends on eur_pkg, eur_cfg, eur_core and ultrasonic_echo_ranger_unit_macros.svh
//
// usage
//   in channel: one word per microsecond tick, carrying start_request and the
//   sampled echo_level. out channel: exactly one word per in word, carrying
//   trigger_out, busy_res, result_valid, distance_cm and timed_out.
//   cfg channel: cfg_index selects trigger width, rise timeout, echo max or
//   hold-off; cfg_ready is always high; indexes beyond the list are dropped.
//   write config only while no tick is in flight.
// pipeline and throughput
//   a tick is captured in the input register at its accepting edge, then the
//   sequencer updates its phase and counter as the word moves into the result
//   register, where the result is offered; that move waits while the result
//   register is full and not being taken. one tick per cycle is sustained
//   while out_ready stays high.
// reset
//   registers return to their defaults, the sequencer goes idle with a zero
//   count and both stages are emptied.
// stall
//   while out_ready is low the result register holds; one more tick waits in
//   the input register, then in_ready drops until the result is taken.
module ultrasonic_echo_ranger_unit
  import eur_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  // input ticks
  input  logic      in_valid,
  output logic      in_ready,
  input  logic      in_start_request,
  input  logic      in_echo_level,
  // results
  output logic      out_valid,
  input  logic      out_ready,
  output logic      out_trigger_out,
  output logic      out_busy_res,
  output logic      out_result_valid,
  output dist_t     out_distance_cm,
  output logic      out_timed_out,
  // configuration writes
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  cfg_idx_t  cfg_index,
  input  cfg_data_t cfg_data
);

  `include "ultrasonic_echo_ranger_unit_macros.svh"

  cfg_t cfg;
  res_t res;

  // input register
  logic s1_valid_r;
  logic s1_start_r;
  logic s1_echo_r;

  // result register
  logic out_valid_r;
  res_t out_res_r;

  logic adv;   // tick moves from input register into result register
  logic s1_take;

  assign cfg_ready = 1'b1;

  eur_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cfg_valid),
    .wr_idx  (cfg_index),
    .wr_data (cfg_data),
    .cfg     (cfg)
  );

  // result register free or being emptied this cycle
  assign adv      = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || adv;
  assign s1_take  = in_valid && in_ready;

  eur_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .start (s1_start_r),
    .echo  (s1_echo_r),
    .cfg   (cfg),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_take) begin
      s1_valid_r <= 1'b1;
    end else if (adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (s1_take) begin
      s1_start_r <= in_start_request;
      s1_echo_r  <= in_echo_level;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_res_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_trigger_out  = out_res_r.trig;
  assign out_busy_res     = out_res_r.busy;
  assign out_result_valid = out_res_r.valid;
  assign out_distance_cm  = out_res_r.dist_cm;
  assign out_timed_out    = out_res_r.tmo;

  // a timeout always reports the code and leaves the block idle
  `EUR_ASSERT_IMPL(a_tmo_word, out_valid_r && out_res_r.tmo,
                   out_res_r.valid && out_res_r.dist_cm == TIMEOUT_CODE && !out_res_r.busy)
  // no finished measurement means zero distance and no timeout flag
  `EUR_ASSERT_IMPL(a_idle_fields, out_valid_r && !out_res_r.valid,
                   out_res_r.dist_cm == '0 && !out_res_r.tmo)
  // an empty result register never blocks the input side
  `EUR_ASSERT_IMPL(a_no_block, !out_valid_r, in_ready)
  // a held tick stays in the input register until it can move on
  `EUR_ASSERT_NEXT(a_s1_hold, s1_valid_r && !adv, s1_valid_r)

endmodule

FILE: tb/ultrasonic_echo_ranger_unit_tb.sv
// testbench for ultrasonic_echo_ranger_unit: tick words go in back to back or as random bursts and gaps,
// results are taken freely or under a stall pattern and checked word by word against a ranging predictor
// depends on eur_pkg and the ultrasonic_echo_ranger_unit rtl
module ultrasonic_echo_ranger_unit_tb
  import eur_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // register indexes past the end of the list, dropped by the block
  localparam int REG_PAST_LAST = int'(REG_HOLDOFF) + 1;
  localparam int REG_IDX_TOP   = 2 ** CFG_IDX_W - 1;

  // random part stops once this many ticks are sent
  localparam int RANDOM_TICKS   = 1500;

  // phases of one ranging cycle
  typedef enum logic [2:0] {
    RG_IDLE,
    RG_TRIGGER,
    RG_WAIT_RISE,
    RG_ECHO,
    RG_HOLDOFF
  } ranger_phase_t;

  // predictor of the ranger plus the store of result words still to come
  class ranger_scoreboard;
    logic [7:0]    trig_width;
    logic [15:0]   rise_tmo;
    logic [15:0]   echo_max;
    logic [16:0]   holdoff;
    ranger_phase_t phase;
    count_t        elapsed;
    res_t          range_words[$];
    int            errors;
    int            ticks;

    function new();
      trig_width = RST_TRIG_WIDTH;
      rise_tmo   = RST_RISE_TMO;
      echo_max   = RST_ECHO_MAX;
      holdoff    = RST_HOLDOFF;
      phase      = RG_IDLE;
      elapsed    = '0;
      errors     = 0;
      ticks      = 0;
    endfunction

    function void report(string msg);
      errors++;
      if (errors <= 40) begin
        $display("error at %0t: %s", $realtime, msg);
      end
    endfunction

    function int pending();
      return range_words.size();
    endfunction

    function bit is_idle();
      return phase == RG_IDLE;
    endfunction

    function void write_reg(cfg_idx_t idx, cfg_data_t d);
      case (idx)
        REG_TRIG_WIDTH: trig_width = d[7:0];
        REG_RISE_TMO:   rise_tmo   = d[15:0];
        REG_ECHO_MAX:   echo_max   = d[15:0];
        REG_HOLDOFF:    holdoff    = d;
        default: ;
      endcase
    endfunction

    // counter that sticks at all ones
    function count_t bump(count_t v);
      return (v == CNT_MAX) ? v : v + 1'b1;
    endfunction

    // one tick through the sequencer, result word queued
    function void note_tick(logic start, logic echo);
      res_t   w;
      count_t e;
      count_t width;
      int     q;
      w     = '0;
      width = (trig_width == 8'd0) ? count_t'(1) : count_t'(trig_width);
      ticks++;
      if (phase == RG_IDLE && start) begin
        phase   = RG_TRIGGER;
        elapsed = '0;
      end
      case (phase)
        RG_TRIGGER: begin
          w.trig = 1'b1;
          e = bump(elapsed);
          if (e >= width || e == CNT_MAX) begin
            phase   = RG_WAIT_RISE;
            elapsed = '0;
          end else begin
            elapsed = e;
          end
        end
        RG_WAIT_RISE: begin
          if (echo) begin
            phase   = RG_ECHO;
            elapsed = '0;
          end else begin
            e = bump(elapsed);
            if (e > rise_tmo || e == CNT_MAX) begin
              w.valid   = 1'b1;
              w.tmo     = 1'b1;
              w.dist_cm = TIMEOUT_CODE;
              phase     = RG_IDLE;
              elapsed   = '0;
            end else begin
              elapsed = e;
            end
          end
        end
        RG_ECHO: begin
          e = bump(elapsed);
          if (!echo) begin
            w.valid = 1'b1;
            q = int'(e) / CM_DIV;
            if (q > int'(TIMEOUT_CODE)) begin
              q = int'(TIMEOUT_CODE);
            end
            w.dist_cm = dist_t'(q);
            elapsed   = '0;
            phase     = (holdoff == '0) ? RG_IDLE : RG_HOLDOFF;
          end else if (e > echo_max || e == CNT_MAX) begin
            w.valid   = 1'b1;
            w.tmo     = 1'b1;
            w.dist_cm = TIMEOUT_CODE;
            phase     = RG_IDLE;
            elapsed   = '0;
          end else begin
            elapsed = e;
          end
        end
        RG_HOLDOFF: begin
          e = bump(elapsed);
          if (e >= holdoff || e == CNT_MAX) begin
            phase   = RG_IDLE;
            elapsed = '0;
          end else begin
            elapsed = e;
          end
        end
        default: ;
      endcase
      w.busy = (phase != RG_IDLE);
      range_words.push_back(w);
    endfunction

    function void check_word(res_t got);
      res_t want;
      if (range_words.size() == 0) begin
        report("result word with nothing expected");
      end else begin
        want = range_words.pop_front();
        if (got.trig !== want.trig) begin
          report($sformatf("trigger_out got %b want %b", got.trig, want.trig));
        end
        if (got.busy !== want.busy) begin
          report($sformatf("busy_res got %b want %b", got.busy, want.busy));
        end
        if (got.valid !== want.valid) begin
          report($sformatf("result_valid got %b want %b", got.valid, want.valid));
        end
        if (got.dist_cm !== want.dist_cm) begin
          report($sformatf("distance_cm got %0d want %0d", got.dist_cm, want.dist_cm));
        end
        if (got.tmo !== want.tmo) begin
          report($sformatf("timed_out got %b want %b", got.tmo, want.tmo));
        end
      end
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  logic      in_start_request = 1'b0;
  logic      in_echo_level = 1'b0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  logic      out_trigger_out;
  logic      out_busy_res;
  logic      out_result_valid;
  dist_t     out_distance_cm;
  logic      out_timed_out;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  cfg_idx_t  cfg_index = '0;
  cfg_data_t cfg_data = '0;

  ranger_scoreboard sb = new();

  // sender and receiver pacing
  bit sender_idling = 1'b0;
  bit rx_stalls = 1'b0;
  bit at_slot = 1'b0;
  int burst_left = 0;
  int rx_pos = 0;
  int rx_hold = 0;
  logic [15:0] rx_pattern = '1;
  res_t got_word;

  ultrasonic_echo_ranger_unit dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // monitor: config writes, accepted ticks and result words, all seen at the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        sb.write_reg(cfg_index, cfg_data);
      end
      if (in_valid && in_ready) begin
        sb.note_tick(in_start_request, in_echo_level);
      end
      if (out_valid && out_ready) begin
        got_word.trig    = out_trigger_out;
        got_word.busy    = out_busy_res;
        got_word.valid   = out_result_valid;
        got_word.dist_cm = out_distance_cm;
        got_word.tmo     = out_timed_out;
        sb.check_word(got_word);
      end
    end
  end

  // receiver: rotating 16-bit ready pattern, now and then a long stall
  always @(negedge clk) begin
    if (!rx_stalls) begin
      out_ready = 1'b1;
    end else if (rx_hold > 0) begin
      out_ready = 1'b0;
      rx_hold--;
    end else begin
      if (rx_pos == 0) begin
        rx_pattern = ($urandom_range(3, 0) == 0) ? '1 : 16'($urandom) | 16'($urandom);
      end
      out_ready = rx_pattern[rx_pos];
      rx_pos = (rx_pos + 1) % 16;
      if ($urandom_range(255, 0) == 0) begin
        rx_hold = $urandom_range(30, 8);
      end
    end
  end

  // get to the falling edge where the next tick is driven, with a gap between bursts
  task automatic wait_slot();
    int gap;
    if (at_slot) begin
      at_slot = 1'b0;
    end else begin
      @(negedge clk);
      if (sender_idling) begin
        if (burst_left == 0) begin
          burst_left = ($urandom_range(7, 0) == 0) ? $urandom_range(300, 100)
                                                   : $urandom_range(40, 1);
          gap = $urandom_range(5, 1);
          in_valid = 1'b0;
          repeat (gap) @(negedge clk);
        end
        burst_left--;
      end
    end
  endtask

  task automatic drive_tick(logic s, logic e);
    in_valid         = 1'b1;
    in_start_request = s;
    in_echo_level    = e;
    do @(posedge clk); while (!in_ready);
  endtask

  // stop sending until every result word is back
  task automatic drain();
    if (at_slot) begin
      at_slot = 1'b0;
    end else begin
      @(negedge clk);
    end
    in_valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic cfg_write(cfg_idx_t idx, cfg_data_t d);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = d;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // all four registers plus one dropped index, random bits above each field
  task automatic set_config(int tw, int rt, int em, int ho);
    cfg_data_t d;
    drain();
    d = cfg_data_t'($urandom);
    d[7:0] = tw[7:0];
    cfg_write(REG_TRIG_WIDTH, d);
    d = cfg_data_t'($urandom);
    d[15:0] = rt[15:0];
    cfg_write(REG_RISE_TMO, d);
    d = cfg_data_t'($urandom);
    d[15:0] = em[15:0];
    cfg_write(REG_ECHO_MAX, d);
    cfg_write(REG_HOLDOFF, cfg_data_t'(ho));
    cfg_write(cfg_idx_t'($urandom_range(REG_IDX_TOP, REG_PAST_LAST)), cfg_data_t'($urandom));
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // a cycle cut short: start on the first tick, echo pulse after it, no wait for idle
  task automatic run_partial(int n, int rise_at, int high_len);
    logic e;
    for (int t = 0; t < n; t++) begin
      wait_slot();
      e = (t >= rise_at) && (t < rise_at + high_len);
      drive_tick(t == 0, e);
    end
  endtask

  // one ranging cycle: idle lead-in, start, echo pulse relative to the start tick,
  // then ticks until the predictor is idle again
  task automatic run_measure(int lead, int rise_at, int high_len, bit start_noise,
                             bit echo_noise);
    int   t;
    bit   started;
    logic s;
    logic e;
    t       = 0;
    started = 1'b0;
    forever begin
      wait_slot();
      if (started && sb.is_idle()) begin
        // already at a drive edge, hand it to whatever comes next
        at_slot = 1'b1;
        break;
      end
      if (!started) begin
        e = 1'($urandom);
        if (!sb.is_idle()) begin
          s = start_noise ? 1'($urandom) : 1'b0;
        end else if (lead > 0) begin
          s = 1'b0;
          lead--;
        end else begin
          s = 1'b1;
          started = 1'b1;
        end
      end else begin
        t++;
        // start while busy must be ignored
        s = start_noise ? ($urandom_range(3, 0) == 0) : 1'b0;
        e = (t >= rise_at) && (t < rise_at + high_len);
        if (echo_noise && $urandom_range(15, 0) == 0) begin
          e = ~e;
        end
      end
      drive_tick(s, e);
    end
  endtask

  initial begin
    int tw;
    int rt;
    int em;
    int ho;
    int w_eff;
    int lead;
    int rise_at;
    int high_len;
    int measures;
    int tick_base;
    bit sn;
    bit en;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset values: ten-tick trigger then waiting for the rise, back to back
    sender_idling = 1'b0;
    rx_stalls     = 1'b0;
    run_partial(30, 40, 0);

    // low extremes, zero trigger width treated as one tick, zero hold-off
    sender_idling = 1'b1;
    rx_stalls     = 1'b1;
    set_config(0, 1, 1, 0);
    run_measure(0, 1, 1, 1'b0, 1'b0);
    run_measure(1, 1, 0, 1'b0, 1'b0);
    run_measure(0, 1, 5, 1'b0, 1'b0);
    run_measure(0, 1, 1, 1'b1, 1'b0);

    // widest trigger, echo seen during the trigger is ignored, starts during hold-off
    set_config(255, 300, 200, 3);
    run_measure(0, 260, 116, 1'b1, 1'b0);
    run_measure(0, 100, 116, 1'b0, 1'b0);

    // high register values: good measurement, then hold-off cut short by new settings
    sender_idling = 1'b0;
    rx_stalls     = 1'b0;
    set_config(1, 65535, 65535, 131071);
    run_partial(400, 5, 300);

    // random part: mostly well-formed cycles under small settings
    sender_idling = 1'b1;
    rx_stalls     = 1'b1;
    measures  = 0;
    tick_base = sb.ticks;
    while ((sb.ticks - tick_base) < RANDOM_TICKS) begin
      if (measures % 2 == 0) begin
        tw = ($urandom_range(9, 0) == 0) ? 0 : $urandom_range(8, 1);
        rt = $urandom_range(30, 1);
        em = ($urandom_range(3, 0) == 0) ? $urandom_range(700, 59) : $urandom_range(120, 1);
        ho = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(20, 1);
        set_config(tw, rt, em, ho);
      end
      w_eff = (tw == 0) ? 1 : tw;
      lead  = $urandom_range(3, 0);
      sn    = ($urandom_range(9, 0) < 3);
      if ($urandom_range(9, 0) < 8) begin
        // echo rises inside the wait window and falls before the echo limit
        rise_at  = $urandom_range(w_eff + rt, w_eff);
        high_len = $urandom_range(em + 1, 1);
        en       = 1'b0;
      end else begin
        rise_at  = $urandom_range(w_eff + rt + 3, 1);
        high_len = $urandom_range(em + 3, 0);
        en       = 1'($urandom);
      end
      run_measure(lead, rise_at, high_len, sn, en);
      measures++;
    end

    drain();
    repeat (8) @(posedge clk);
    if (sb.pending() != 0) begin
      sb.report($sformatf("%0d result words never arrived", sb.pending()));
    end
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // watchdog, far beyond the slowest correct run
  initial begin
    #20_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl/core
rtl/core/eur_pkg.sv
rtl/core/eur_cfg.sv
rtl/core/eur_core.sv
rtl/core/ultrasonic_echo_ranger_unit.sv
tb/ultrasonic_echo_ranger_unit_tb.sv
